FILE: rtl/assert_macros.svh
// Assertion macros shared by the decimal printer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/uda_pkg.sv
// Types and constants of the 64-bit decimal ASCII printer.
package uda_pkg;

  localparam int VALUE_W    = 64;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 6;
  localparam int MAX_DIGITS = 20;
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int STEP_W     = 8;
  localparam int STEPS      = VALUE_W / STEP_W;
  localparam int BCNT_W     = $clog2(STEPS);
  localparam int DIV_IN_W   = DIGIT_W + STEP_W;
  localparam int RADIX      = 10;
  localparam int DIV_RECIP  = 6554;
  localparam int DIV_SHIFT  = 16;
  localparam int RECIP_W    = 13;
  localparam int PROD_W     = DIV_IN_W + RECIP_W;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_LOAD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   addr;
    logic [DIGIT_W-1:0] data;
  } store_wr_t;

endpackage

FILE: rtl/uda_div10_step.sv
// One long-division step: remainder and next byte divided by ten.
module uda_div10_step (
  input  logic [uda_pkg::DIV_IN_W-1:0] x,
  output logic [uda_pkg::STEP_W-1:0]   q,
  output logic [uda_pkg::DIGIT_W-1:0]  r
);
  import uda_pkg::*;

  logic [PROD_W-1:0]   prod;
  logic [DIV_IN_W-1:0] back;
  logic [DIV_IN_W-1:0] diff;

  assign prod = PROD_W'(x) * PROD_W'(DIV_RECIP);
  assign q    = prod[DIV_SHIFT +: STEP_W];
  assign back = DIV_IN_W'(q) * DIV_IN_W'(RADIX);
  assign diff = x - back;
  assign r    = diff[DIGIT_W-1:0];

endmodule

FILE: rtl/uda_digit_store.sv
// Generic RAM: one write port, one registered read port, no reset.
module uda_digit_store #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 20,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/uint64_to_decimal_ascii_unit.sv
// Top level of the 64-bit unsigned to decimal ASCII printer.
// Each digit is found by running the shared byte-wide divide-by-ten step over every
// byte of the value, most significant byte first. A value of D digits (1 to 20) then
// gives its characters most significant first, one per cycle when not stalled.
// A new request is taken once the last character of the previous one is on the output.
// rst clears the sequencer, the digit count and the output valid.
`include "assert_macros.svh"

module uint64_to_decimal_ascii_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [uda_pkg::VALUE_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [uda_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last
);
  import uda_pkg::*;

  state_t              state, state_next;
  logic [VALUE_W-1:0]  quo, quo_next;
  logic [DIGIT_W-1:0]  rem, rem_next;
  logic [BCNT_W-1:0]   bcnt, bcnt_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [IDX_W-1:0]    eidx, eidx_next;
  logic                out_valid_next;
  logic [CHAR_W-1:0]   digit_char_next;
  logic                last_next;
  logic [STEP_W-1:0]   step_q;
  logic [DIGIT_W-1:0]  step_r;
  logic [VALUE_W-1:0]  quo_shift;
  logic [DIGIT_W-1:0]  rd;
  store_wr_t           wr;

  uda_div10_step u_step (
    .x ({rem, quo[VALUE_W-1 -: STEP_W]}),
    .q (step_q),
    .r (step_r)
  );

  uda_digit_store #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (eidx_next),
    .rdata (rd)
  );

  assign quo_shift = {quo[VALUE_W-STEP_W-1:0], step_q};
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
    quo        <= quo_next;
    rem        <= rem_next;
    bcnt       <= bcnt_next;
    eidx       <= eidx_next;
    digit_char <= digit_char_next;
    last       <= last_next;
  end

  always_comb begin
    state_next      = state;
    quo_next        = quo;
    rem_next        = rem;
    bcnt_next       = bcnt;
    cnt_next        = cnt;
    eidx_next       = eidx;
    out_valid_next  = out_valid;
    digit_char_next = digit_char;
    last_next       = last;
    wr              = '0;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          quo_next   = value;
          rem_next   = '0;
          bcnt_next  = '0;
          cnt_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        quo_next  = quo_shift;
        rem_next  = step_r;
        bcnt_next = BCNT_W'(bcnt + 1'b1);
        if (bcnt == BCNT_W'(STEPS - 1)) begin
          rem_next = '0;
          if (cnt < CNT_W'(MAX_DIGITS)) begin
            wr.we    = 1'b1;
            wr.addr  = cnt[IDX_W-1:0];
            wr.data  = step_r;
            cnt_next = CNT_W'(cnt + 1'b1);
          end
          if (quo_shift == '0) begin
            eidx_next  = IDX_W'(cnt_next - 1'b1);
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next  = 1'b1;
          digit_char_next = CHAR_ZERO + CHAR_W'(rd);
          last_next       = (eidx == '0);
          if (eidx == '0) begin
            state_next = S_IDLE;
          end else begin
            eidx_next = IDX_W'(eidx - 1'b1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_cnt_bound, clk, rst, cnt <= CNT_W'(MAX_DIGITS), "digit count above store depth")
  `ASSERT_CLK(a_emit_idx, clk, rst, (state == S_EMIT) |-> (CNT_W'(eidx) < cnt), "emit index past count")
  `ASSERT_CLK(a_rem_digit, clk, rst, (state == S_DIV) |-> (rem < DIGIT_W'(RADIX)), "remainder not a digit")
  `ASSERT_CLK(a_rst_out, clk, rst, $past(rst) |-> !out_valid, "output valid after reset")

endmodule

FILE: test/uint64_to_decimal_ascii_checker.sv
// Checker for the decimal ASCII printer: predicts digit characters per request and compares.
module uint64_to_decimal_ascii_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [uda_pkg::VALUE_W-1:0] value,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [uda_pkg::CHAR_W-1:0]  digit_char,
  input  logic                        last,
  output int                          fail_count,
  output int                          outstanding
);
  import uda_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } char_item_t;

  char_item_t expected_chars[$];
  int         errors = 0;

  function automatic void predict_chars(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] digits [MAX_DIGITS];
    logic [VALUE_W-1:0] rem;
    int                 n;
    char_item_t         item;
    quotient = v;
    n = 0;
    do begin
      rem = quotient % RADIX;
      quotient = quotient / RADIX;
      if (n < MAX_DIGITS) begin
        digits[n] = rem[DIGIT_W-1:0];
        n++;
      end
    end while (quotient != 0);
    for (int k = n - 1; k >= 0; k--) begin
      item.digit_char = CHAR_ZERO + CHAR_W'(digits[k]);
      item.last       = (k == 0);
      expected_chars.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    char_item_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual char %0d last %0b",
                   $time, digit_char, last);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (digit_char !== want.digit_char) begin
            $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                     $time, want.digit_char, digit_char);
            errors++;
          end
          if (last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_chars(value);
      end
    end
    fail_count  <= errors;
    outstanding <= expected_chars.size();
  end

endmodule

FILE: test/tb_top.sv
// Testbench top for the decimal ASCII printer: clock, reset, request stimulus and verdict.
module tb_top;
  import uda_pkg::*;

  localparam int RANDOM_REQUESTS = 208;
  localparam int QUIET_REQUESTS  = 30;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] value      = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [CHAR_W-1:0]  digit_char;
  logic               last;
  logic               quiet      = 1'b0;
  int                 fail_count;
  int                 outstanding;

  uint64_to_decimal_ascii_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digit_char(digit_char),
    .last      (last)
  );

  uint64_to_decimal_ascii_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last       (last),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_request(input logic [VALUE_W-1:0] v);
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, quiet ? 1 : ($urandom_range(0, 3) == 0 ? 60 : 12)))
        @(posedge clk);
    end
  end

  initial begin
    logic [VALUE_W-1:0] directed [] = '{
      64'd0, 64'd1, 64'd7, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100, 64'd12345,
      64'd1000000000, 64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
      64'd1000000000000000000, 64'd9999999999999999999, 64'd10000000000000000000,
      64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555, 64'd1844674407370955161, 64'hFFFF_FFFF_FFFF_FFFE,
      64'hFFFF_FFFF_FFFF_FFFF
    };
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] power;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      send_request(directed[i]);
    end
    drain_results();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS - QUIET_REQUESTS) begin
        drain_results();
        quiet <= 1'b1;
      end else if (i > 0 && $urandom_range(0, 49) == 0) begin
        drain_results();
      end
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: ;
        1: v = v >> $urandom_range(1, 63);
        2: v = v >> $urandom_range(44, 63);
        default: begin
          power = 64'd1;
          repeat ($urandom_range(0, 19)) power = power * 64'd10;
          v = power + VALUE_W'($urandom_range(0, 2)) - 64'd1;
        end
      endcase
      if (!quiet && $urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      send_request(v);
    end
    drain_results();
    repeat (200) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
